### hw/rtl/heat_stencil_update_assert.svh
// Assertion macros used by the checker of the stencil block.
// All use clk as the sampling clock and are off while arst_n is low.
`ifndef HEAT_STENCIL_UPDATE_ASSERT_SVH
`define HEAT_STENCIL_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define HSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/hsu_pkg.sv
`default_nettype none

package hsu_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int FRAC_W     = 16;
	localparam int WEIGHT_W   = 16;
	localparam int NCOL_CFG_W = 11;
	localparam int ROW_CFG_W  = 10;
	localparam int ROW_OUT_W  = 10;
	localparam int COL_OUT_W  = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// down + up - 2*old needs two guard bits
	localparam int SUM_W  = SAMPLE_W + 2;
	localparam int PROD_W = SUM_W + WEIGHT_W + 1;
	localparam int ACC_W  = SUM_W + 3;

	localparam int MIN_COLUMNS = 3;

	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = 3;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_ROW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y    = 3'd4;

	localparam logic [NCOL_CFG_W-1:0] RST_NUM_COLUMNS = 11'd1024;
	localparam logic [ROW_CFG_W-1:0]  RST_FIRST_ROW   = 10'd1;
	localparam logic [ROW_CFG_W-1:0]  RST_LAST_ROW    = 10'd1022;
	// 0.1 in Q0.16
	localparam logic [WEIGHT_W-1:0]   RST_WEIGHT      = 16'd6554;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic [WEIGHT_W-1:0]        weight_t;

	// five-point neighborhood of one cell
	typedef struct packed {
		sample_t old_v;
		sample_t up_v;
		sample_t down_v;
		sample_t left_v;
		sample_t right_v;
	} stencil_t;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
	} cell_pos_t;

	typedef struct packed {
		sample_t              new_value;
		logic [ROW_OUT_W-1:0] cell_row;
		logic [COL_OUT_W-1:0] cell_column;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/hsu_if.sv
`default_nettype none

interface hsu_in_if;
	logic                    valid;
	logic                    ready;
	logic [31:0]             sample;
	logic                    grid_start;

	modport source (output valid, output sample, output grid_start, input ready);
	modport sink   (input valid, input sample, input grid_start, output ready);
endinterface

interface hsu_out_if;
	logic                    valid;
	logic                    ready;
	logic [31:0]             new_value;
	logic [9:0]              cell_row;
	logic [9:0]              cell_column;

	modport source (output valid, output new_value, output cell_row, output cell_column,
		input ready);
	modport sink   (input valid, input new_value, input cell_row, input cell_column,
		output ready);
endinterface

interface hsu_cfg_if;
	logic                    valid;
	logic                    ready;
	logic [2:0]              index;
	logic [15:0]             data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/hsu_linebuf.sv
`default_nettype none

module hsu_linebuf #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 accept,
	input  wire [hsu_pkg::SAMPLE_W-1:0]         sample,
	input  wire                                 grid_start,
	input  wire [$clog2(MAX_COLUMNS+1)-1:0]     ncols,
	input  wire [hsu_pkg::ROW_CFG_W-1:0]        first_row,
	input  wire [hsu_pkg::ROW_CFG_W-1:0]        last_row,
	output logic                                emit_s1,
	output hsu_pkg::stencil_t                   taps_s1,
	output hsu_pkg::cell_pos_t                  pos_s1
);
	import hsu_pkg::*;

	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

	logic [SAMPLE_W-1:0] prev_mem [MAX_COLUMNS];
	logic [SAMPLE_W-1:0] two_mem  [MAX_COLUMNS];

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] base_col, cur_col, nxt_col, col_plus;
	logic [RW-1:0] base_row, cur_row, nxt_row;
	logic [31:0]   ncols32, c32, r32;
	logic          emit;
	logic          fwd;

	logic                valid_s1;
	logic [CW-1:0]       col_s1;
	logic                fwd_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] old_rd_s1, right_rd_s1, up_rd_s1;
	logic [SAMPLE_W-1:0] left_q;
	cell_pos_t           pos_r_s1;

	assign ncols32 = 32'(ncols);

	// position of this word, then of the next one
	always_comb begin
		base_col = grid_start ? '0 : col_q;
		base_row = grid_start ? '0 : row_q;
		cur_col  = base_col;
		cur_row  = base_row;
		if (32'(base_col) >= ncols32) begin
			cur_col = '0;
			cur_row = (base_row == ROW_LAST) ? '0 : RW'(base_row + 1'b1);
		end
		nxt_col = CW'(cur_col + 1'b1);
		nxt_row = cur_row;
		if (32'(cur_col) + 32'd1 >= ncols32) begin
			nxt_col = '0;
			nxt_row = (cur_row == ROW_LAST) ? '0 : RW'(cur_row + 1'b1);
		end
	end

	assign c32      = 32'(cur_col);
	assign r32      = 32'(cur_row);
	assign col_plus = CW'(c32 + 32'd1);

	assign emit = (r32 >= 32'd2) && (c32 >= 32'd1) && (c32 + 32'd2 <= ncols32) &&
		(r32 - 32'd1 >= 32'(first_row)) && (r32 - 32'd1 <= 32'(last_row));

	// older store is written in the cycle after the accept; bypass when the same column follows
	assign fwd = valid_s1 && (col_s1 == cur_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			emit_s1  <= accept && emit;
			if (accept) begin
				col_q <= nxt_col;
				row_q <= nxt_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= cur_col;
			fwd_s1    <= fwd;
			sample_s1 <= sample;
			pos_r_s1  <= '{row: ROW_OUT_W'(r32 - 32'd1), col: COL_OUT_W'(c32)};
		end
		if (valid_s1) begin
			left_q <= old_rd_s1;
		end
	end

	// row r-1 store: read-first, old and right neighbor
	always_ff @(posedge clk) begin
		old_rd_s1   <= prev_mem[cur_col];
		right_rd_s1 <= prev_mem[col_plus];
		if (accept) begin
			prev_mem[cur_col] <= sample;
		end
	end

	// row r-2 store, takes what leaves the row r-1 store
	always_ff @(posedge clk) begin
		up_rd_s1 <= two_mem[cur_col];
		if (valid_s1) begin
			two_mem[col_s1] <= old_rd_s1;
		end
	end

	assign taps_s1 = '{
		old_v:   old_rd_s1,
		up_v:    fwd_s1 ? left_q : up_rd_s1,
		down_v:  sample_s1,
		left_v:  left_q,
		right_v: right_rd_s1
	};
	assign pos_s1 = pos_r_s1;

endmodule

`default_nettype wire

### hw/rtl/hsu_arith.sv
`default_nettype none

module hsu_arith (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          emit_s1,
	input  hsu_pkg::stencil_t            taps_s1,
	input  hsu_pkg::cell_pos_t           pos_s1,
	input  wire [hsu_pkg::WEIGHT_W-1:0]  weight_x,
	input  wire [hsu_pkg::WEIGHT_W-1:0]  weight_y,
	output logic                         push,
	output hsu_pkg::result_t             result,
	output logic [1:0]                   pending
);
	import hsu_pkg::*;

	logic      emit_s2, emit_s3;
	sum_t      vert_s2, horz_s2;
	sample_t   old_s2, old_s3;
	cell_pos_t pos_s2, pos_s3;
	prod_t     pv_s3, ph_s3;
	sum_t      twice_old;
	acc_t      acc;
	sample_t   sat;

	assign twice_old = SUM_W'(taps_s1.old_v) <<< 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
		end else begin
			emit_s2 <= emit_s1;
			emit_s3 <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		vert_s2 <= SUM_W'(taps_s1.down_v) + SUM_W'(taps_s1.up_v) - twice_old;
		horz_s2 <= SUM_W'(taps_s1.right_v) + SUM_W'(taps_s1.left_v) - twice_old;
		old_s2  <= taps_s1.old_v;
		pos_s2  <= pos_s1;

		pv_s3  <= PROD_W'($signed({1'b0, weight_x})) * PROD_W'(vert_s2);
		ph_s3  <= PROD_W'($signed({1'b0, weight_y})) * PROD_W'(horz_s2);
		old_s3 <= old_s2;
		pos_s3 <= pos_s2;
	end

	// arithmetic shift floors; then clamp to 32 bits
	always_comb begin
		acc = ACC_W'(old_s3) + ACC_W'(pv_s3 >>> FRAC_W) + ACC_W'(ph_s3 >>> FRAC_W);
		if (acc[ACC_W-1:SAMPLE_W-1] == '0 || acc[ACC_W-1:SAMPLE_W-1] == '1) begin
			sat = acc[SAMPLE_W-1:0];
		end else if (acc[ACC_W-1]) begin
			sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	assign push    = emit_s3;
	assign result  = '{new_value: sat, cell_row: pos_s3.row, cell_column: pos_s3.col};
	assign pending = 2'(emit_s2) + 2'(emit_s3);

endmodule

`default_nettype wire

### hw/rtl/hsu_outq.sv
`default_nettype none

module hsu_outq (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	input  hsu_pkg::result_t             wdata,
	input  wire                          pop,
	output logic                         rvalid,
	output hsu_pkg::result_t             rdata,
	output logic [hsu_pkg::OUTQ_AW:0]    count
);
	import hsu_pkg::*;

	result_t              fifo_mem [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OUTQ_AW:0]     count_q;
	logic                 do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (OUTQ_AW+1)'(push) - (OUTQ_AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= wdata;
		end
	end

	assign rvalid = (count_q != '0);
	assign rdata  = fifo_mem[rd_ptr_q];
	assign count  = count_q;

endmodule

`default_nettype wire

### hw/rtl/heat_stencil_update.sv
// Path: a result word passes the stage 1, 2 and 3 registers, then is written into the
//   output queue, and is valid on the output once it is the oldest queued word.
// Throughput: one sample per cycle, sustained, as long as the output drains;
//   the line stores are read and written in the same cycle and every stage moves each cycle.
// Reset (arst_n low, async): position back to row 0 column 0, pipeline and output
//   queue emptied, registers to 1024, 1, 1022, 6554, 6554. Line stores are not cleared.
`default_nettype none

module heat_stencil_update #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  wire        clk,
	input  wire        arst_n,
	hsu_in_if.sink     samples,
	hsu_out_if.source  results,
	hsu_cfg_if.sink    cfg
);
	import hsu_pkg::*;

	localparam int NCW = $clog2(MAX_COLUMNS + 1);

	// ---------------------------------------------------------------
	// Configuration registers. Always ready; unknown indexes dropped.
	// ---------------------------------------------------------------
	logic [NCOL_CFG_W-1:0] num_columns_q;
	logic [ROW_CFG_W-1:0]  first_row_q;
	logic [ROW_CFG_W-1:0]  last_row_q;
	weight_t               weight_x_q;
	weight_t               weight_y_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_columns_q <= RST_NUM_COLUMNS;
			first_row_q   <= RST_FIRST_ROW;
			last_row_q    <= RST_LAST_ROW;
			weight_x_q    <= RST_WEIGHT;
			weight_y_q    <= RST_WEIGHT;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NUM_COLUMNS: num_columns_q <= cfg.data[NCOL_CFG_W-1:0];
				REG_FIRST_ROW:   first_row_q   <= cfg.data[ROW_CFG_W-1:0];
				REG_LAST_ROW:    last_row_q    <= cfg.data[ROW_CFG_W-1:0];
				REG_WEIGHT_X:    weight_x_q    <= cfg.data;
				REG_WEIGHT_Y:    weight_y_q    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Row length clamped to [3, MAX_COLUMNS]
	logic [31:0]    ncfg32;
	logic [NCW-1:0] ncols_eff;

	assign ncfg32 = 32'(num_columns_q);

	always_comb begin
		if (ncfg32 < 32'(MIN_COLUMNS)) begin
			ncols_eff = NCW'(MIN_COLUMNS);
		end else if (ncfg32 > 32'(MAX_COLUMNS)) begin
			ncols_eff = NCW'(MAX_COLUMNS);
		end else begin
			ncols_eff = NCW'(ncfg32);
		end
	end

	// ---------------------------------------------------------------
	// Input handshake. The pipeline never stalls, so input ready is a
	// credit check: queued words plus results still in flight must
	// leave a slot for the word accepted now.
	// ---------------------------------------------------------------
	logic               accept;
	logic [OUTQ_AW:0]   q_count;
	logic [1:0]         arith_pending;
	logic [OUTQ_AW+1:0] committed;

	logic      emit_s1;
	stencil_t  taps_s1;
	cell_pos_t pos_s1;

	assign committed = (OUTQ_AW+2)'(q_count) + (OUTQ_AW+2)'(arith_pending)
		+ (OUTQ_AW+2)'(emit_s1);
	assign samples.ready = (committed < (OUTQ_AW+2)'(OUTQ_DEPTH));
	assign accept        = samples.valid && samples.ready;

	// Stage 0/1: position tracking and both line stores.
	hsu_linebuf #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_linebuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.sample     (samples.sample),
		.grid_start (samples.grid_start),
		.ncols      (ncols_eff),
		.first_row  (first_row_q),
		.last_row   (last_row_q),
		.emit_s1    (emit_s1),
		.taps_s1    (taps_s1),
		.pos_s1     (pos_s1)
	);

	// Stages 2/3: neighbor sums, weight multiplies, shift, add, saturate.
	logic    push;
	result_t result;

	hsu_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit_s1  (emit_s1),
		.taps_s1  (taps_s1),
		.pos_s1   (pos_s1),
		.weight_x (weight_x_q),
		.weight_y (weight_y_q),
		.push     (push),
		.result   (result),
		.pending  (arith_pending)
	);

	// Output queue decouples the result side from the sample side.
	result_t q_data;

	hsu_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (result),
		.pop    (results.ready),
		.rvalid (results.valid),
		.rdata  (q_data),
		.count  (q_count)
	);

	assign results.new_value   = q_data.new_value;
	assign results.cell_row    = q_data.cell_row;
	assign results.cell_column = q_data.cell_column;

endmodule

`default_nettype wire

### hw/rtl/hsu_checker.sv
`default_nettype none

`include "heat_stencil_update_assert.svh"

module hsu_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] new_value,
	input wire [9:0]  cell_row,
	input wire [9:0]  cell_column
);

	`HSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_value) && $stable(cell_row) && $stable(cell_column), "result word changed while stalled")

	`HSU_ASSERT_NOW(a_col_interior, out_valid, cell_column != 10'd0, "result on border column")

	`HSU_ASSERT_NOW(a_row_interior, out_valid, cell_row != 10'd0, "result on border row")

	`HSU_ASSERT_NOW(a_min_latency, $rose(out_valid), $past(in_valid && in_ready, 4), "result without sample four cycles earlier")

endmodule

bind heat_stencil_update hsu_checker u_hsu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.new_value   (results.new_value),
	.cell_row    (results.cell_row),
	.cell_column (results.cell_column)
);

`default_nettype wire

### sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hsu_pkg::*;

	// Geometry of the instance under test (default parameters)
	localparam int LINE_LEN  = 1024;
	localparam int GRID_ROWS = 1024;

	// Unused register index; writes to it must leave every register alone
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	// Longest quiet stretch tolerated, and the length of the long receiver hold
	localparam int STALL_LIMIT  = 2000;
	localparam int LONG_HOLD    = 300;
	// Pipeline is 4 deep; allow a margin before touching config or ending
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 300;

	typedef struct {
		logic [31:0] value;
		logic        grid_start;
	} raster_word_t;

	logic clk;
	logic arst_n;

	hsu_in_if  samples_if ();
	hsu_out_if results_if ();
	hsu_cfg_if cfg_if ();

	heat_stencil_update DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shared state between stimulus, driver, receiver and monitor
	// ------------------------------------------------------------------
	raster_word_t pending_words[$];
	result_t      expected_cells[$];

	int items_queued = 0;
	int items_taken  = 0;
	int cells_seen   = 0;
	int reg_writes   = 0;
	int errors       = 0;

	// Idle probability in percent for each side, changed per phase
	int src_idle_pct = 0;
	int snk_idle_pct = 0;

	// Long hold requests from the stimulus; the receiver serves them
	int holds_asked  = 0;
	int holds_served = 0;

	// ------------------------------------------------------------------
	// Predictor: own copy of the line stores, raster position and regs
	// ------------------------------------------------------------------
	logic [31:0] prev_row_vals  [LINE_LEN];
	logic [31:0] older_row_vals [LINE_LEN];
	int next_row = 0;
	int next_col = 0;

	int cols_reg  = RST_NUM_COLUMNS;
	int first_reg = RST_FIRST_ROW;
	int last_reg  = RST_LAST_ROW;
	int wx_reg    = RST_WEIGHT;
	int wy_reg    = RST_WEIGHT;

	// Advance the raster position by one sample and, when the cell one row
	// up is an update cell, queue its new value.
	function automatic void predict_cell_update(input logic [31:0] s, input logic gs);
		int n, r, c;
		longint old_v, up_v, down_v, left_v, right_v, vert, horz, acc;
		logic [31:0] old_u;
		result_t upd;
		n = cols_reg;
		if (n < MIN_COLUMNS) n = MIN_COLUMNS;
		if (n > LINE_LEN) n = LINE_LEN;
		if (gs) begin
			next_row = 0;
			next_col = 0;
		end
		// row shrunk under us: wrap to the next row first
		if (next_col >= n) begin
			next_col = 0;
			next_row = (next_row + 1) % GRID_ROWS;
		end
		r = next_row;
		c = next_col;
		old_u = prev_row_vals[c];
		if (r >= 2 && c >= 1 && c + 2 <= n && r - 1 >= first_reg && r - 1 <= last_reg) begin
			old_v   = $signed(old_u);
			up_v    = $signed(older_row_vals[c]);
			down_v  = $signed(s);
			// left has already moved to the older store, right has not
			left_v  = $signed(older_row_vals[c-1]);
			right_v = $signed(prev_row_vals[c+1]);
			vert = down_v + up_v - 2 * old_v;
			horz = right_v + left_v - 2 * old_v;
			// arithmetic shifts: floor toward minus infinity
			acc = old_v + ((longint'(wx_reg) * vert) >>> 16)
				+ ((longint'(wy_reg) * horz) >>> 16);
			if (acc > 64'sd2147483647) acc = 64'sd2147483647;
			if (acc < -64'sd2147483648) acc = -64'sd2147483648;
			upd.new_value   = acc[31:0];
			upd.cell_row    = 10'(r - 1);
			upd.cell_column = 10'(c);
			expected_cells.push_back(upd);
		end
		older_row_vals[c] = old_u;
		prev_row_vals[c]  = s;
		next_col = c + 1;
		if (next_col >= n) begin
			next_col = 0;
			next_row = (r + 1) % GRID_ROWS;
		end
	endfunction

	// ------------------------------------------------------------------
	// Sample driver: feeds pending words, with random idle bursts
	// ------------------------------------------------------------------
	int           src_gap;
	raster_word_t src_word;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid      <= 1'b0;
			samples_if.sample     <= '0;
			samples_if.grid_start <= 1'b0;
			src_gap <= 0;
		end else if (!samples_if.valid || samples_if.ready) begin
			if (src_gap > 0) begin
				samples_if.valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (pending_words.size() == 0) begin
				samples_if.valid <= 1'b0;
			end else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
				samples_if.valid <= 1'b0;
				src_gap <= $urandom_range(0, 3);
			end else begin
				src_word = pending_words.pop_front();
				samples_if.valid      <= 1'b1;
				samples_if.sample     <= src_word.value;
				samples_if.grid_start <= src_word.grid_start;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stalls plus the occasional long hold-off
	// ------------------------------------------------------------------
	int snk_gap;
	int hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			snk_gap      <= 0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served != holds_asked) begin
			results_if.ready <= 1'b0;
			hold_left    <= LONG_HOLD;
			holds_served <= holds_served + 1;
		end else if (hold_left > 0) begin
			results_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (snk_gap > 0) begin
			results_if.ready <= 1'b0;
			snk_gap <= snk_gap - 1;
		end else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct) begin
			results_if.ready <= 1'b0;
			snk_gap <= $urandom_range(0, 3);
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each accepted sample, check each result word
	// ------------------------------------------------------------------
	result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			// prediction first, so a same-edge result can never race it
			if (samples_if.valid && samples_if.ready) begin
				predict_cell_update(samples_if.sample, samples_if.grid_start);
				items_taken++;
			end
			if (results_if.valid && results_if.ready) begin
				cells_seen++;
				if (expected_cells.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: cell (%0d,%0d) value %0d", $time,
						results_if.cell_row, results_if.cell_column,
						$signed(results_if.new_value));
				end else begin
					want = expected_cells.pop_front();
					if (results_if.new_value !== want.new_value) begin
						errors++;
						$display("%0t: new_value expected %0d got %0d", $time,
							want.new_value, $signed(results_if.new_value));
					end
					if (results_if.cell_row !== want.cell_row) begin
						errors++;
						$display("%0t: cell_row expected %0d got %0d", $time,
							want.cell_row, results_if.cell_row);
					end
					if (results_if.cell_column !== want.cell_column) begin
						errors++;
						$display("%0t: cell_column expected %0d got %0d", $time,
							want.cell_column, results_if.cell_column);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no handshake on any channel ends the run
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d words still expected", $time,
				STALL_LIMIT, expected_cells.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// One register write; the predictor takes it at the accepting edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_NUM_COLUMNS: cols_reg  = value[10:0];
			REG_FIRST_ROW:   first_reg = value[9:0];
			REG_LAST_ROW:    last_reg  = value[9:0];
			REG_WEIGHT_X:    wx_reg    = value;
			REG_WEIGHT_Y:    wy_reg    = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic setup(input logic [15:0] ncols, input logic [15:0] first,
			input logic [15:0] last, input logic [15:0] wx, input logic [15:0] wy);
		write_reg(REG_NUM_COLUMNS, ncols);
		write_reg(REG_FIRST_ROW, first);
		write_reg(REG_LAST_ROW, last);
		write_reg(REG_WEIGHT_X, wx);
		write_reg(REG_WEIGHT_Y, wy);
	endtask

	task automatic push_word(input logic [31:0] value, input logic gs);
		raster_word_t w;
		w.value = value;
		w.grid_start = gs;
		pending_words.push_back(w);
		items_queued++;
	endtask

	// Mostly small Q16.16 values so the update stays in range, with a share
	// of full-range words and rail values to hit saturation.
	function automatic logic [31:0] pick_sample();
		case ($urandom_range(9))
			6, 7, 9: return $urandom();
			8: begin
				case ($urandom_range(4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					default: return 32'h0000_0001;
				endcase
			end
			default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		endcase
	endfunction

	// A run of raster samples; fresh marks the first as a grid start,
	// restart_pct sprinkles grid starts in the middle of the grid.
	task automatic queue_grid(input int count, input bit fresh, input int restart_pct);
		logic gs;
		for (int i = 0; i < count; i++) begin
			gs = (i == 0) ? fresh : ($urandom_range(99) < restart_pct);
			push_word(pick_sample(), gs);
		end
	endtask

	// Every word sent, every result back, then let the pipeline settle.
	task automatic wait_idle();
		while (pending_words.size() != 0 || items_taken != items_queued
				|| expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int random_items;
		int phase_no;
		int ncols_w, eff, rows, count, first_w, last_w;

		arst_n = 1'b0;
		samples_if.valid      = 1'b0;
		samples_if.sample     = '0;
		samples_if.grid_start = 1'b0;
		results_if.ready      = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		src_idle_pct = 20;
		snk_idle_pct = 20;

		// Directed: column count below range clamps to 3, first row 0 acts
		// as 1, full weights. A checkerboard of the rails drives the sum into
		// both saturation limits; the lower rows use 0, -1 and 1.
		setup(16'd0, 16'd0, 16'd1023, 16'hFFFF, 16'hFFFF);
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (r < 4)
					push_word(((r + c) % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
						r == 0 && c == 0);
				else
					push_word((c == 0) ? 32'h0000_0000 :
						(c == 1) ? 32'hFFFF_FFFF : 32'h0000_0001, 1'b0);
			end
		end
		wait_idle();

		// Column count above range clamps to the full line of 1024, so the
		// first 64 samples stay in row 0. Narrowing to 12 then wraps the next
		// sample to row 1 and the rows after it update. Spare index write too.
		write_reg(REG_SPARE, 16'hFFFF);
		setup(16'd2047, 16'd1, 16'd1022, 16'd0, 16'd32768);
		queue_grid(64, 1'b1, 0);
		wait_idle();
		write_reg(REG_NUM_COLUMNS, 16'd12);
		queue_grid(4 * 12, 1'b0, 0);
		wait_idle();

		// Row shrinks mid-grid: stop past column 10 of a 40-wide grid, then
		// narrow to 10 so the next sample wraps to the start of a new row.
		setup(16'd40, 16'd1, 16'd1023, pick_weight(), pick_weight());
		queue_grid(4 * 40 + 25, 1'b1, 0);
		wait_idle();
		write_reg(REG_NUM_COLUMNS, 16'd10);
		queue_grid(60, 1'b0, 0);
		wait_idle();

		// Random phases: fresh config each time, mostly narrow grids.
		random_items = 0;
		phase_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0: ncols_w = $urandom_range(0, 2);
				1: ncols_w = $urandom_range(25, 48);
				default: ncols_w = $urandom_range(3, 24);
			endcase
			case ($urandom_range(19))
				0, 1: begin
					first_w = $urandom_range(1000, 1023);
					last_w  = 1023;
				end
				2, 3, 4: begin
					// last row below first row: no updates at all
					first_w = $urandom_range(3, 6);
					last_w  = $urandom_range(0, first_w - 1);
				end
				default: begin
					first_w = $urandom_range(0, 3);
					last_w  = $urandom_range(0, 1) ? 1023 : first_w + $urandom_range(0, 6);
				end
			endcase
			if (phase_no == 0) begin
				// backpressure phase: dense results, steady sender
				ncols_w = 16;
				first_w = 1;
				last_w  = 1023;
			end
			eff = (ncols_w < MIN_COLUMNS) ? MIN_COLUMNS : ncols_w;
			rows = (eff > 24) ? 3 : $urandom_range(3, 8);
			count = rows * eff + $urandom_range(0, eff - 1);

			case ($urandom_range(2))
				0: src_idle_pct = 0;
				1: src_idle_pct = 15;
				default: src_idle_pct = 40;
			endcase
			case ($urandom_range(2))
				0: snk_idle_pct = 0;
				1: snk_idle_pct = 15;
				default: snk_idle_pct = 40;
			endcase
			if (phase_no == 0)
				src_idle_pct = 0;

			setup(16'(ncols_w), 16'(first_w), 16'(last_w), pick_weight(), pick_weight());
			queue_grid(count, 1'b1, 2);
			if (phase_no == 0)
				holds_asked++;
			wait_idle();
			random_items += count;
			phase_no++;
		end

		// Last part, no idling: 3-wide grid of 30 rows, update window rows 1 to 1022.
		// Upper bits of the config words are garbage and must be dropped.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		setup(16'hF803, 16'hFC01, 16'hFFFE, pick_weight(), pick_weight());
		queue_grid(30 * 3, 1'b1, 0);
		wait_idle();

		$display("run covered %0d samples, %0d updated cells checked, %0d register writes",
			items_taken, cells_seen, reg_writes);
		$display("  incl. rail saturation, column clamps, row shrink, long output hold");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/hsu_pkg.sv
hw/rtl/hsu_if.sv
hw/rtl/hsu_linebuf.sv
hw/rtl/hsu_arith.sv
hw/rtl/hsu_outq.sv
hw/rtl/heat_stencil_update.sv
hw/rtl/hsu_checker.sv
sim/testbench.sv
